FILE: rtl/incompatible_pair_difference_masks_assert.svh
// assertion macros for the checker of the pair mask block
// depends on nothing; take in with a plain include
`ifndef INCOMPATIBLE_PAIR_DIFFERENCE_MASKS_ASSERT_SVH
`define INCOMPATIBLE_PAIR_DIFFERENCE_MASKS_ASSERT_SVH

// same-cycle implication
`define IPDM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipdm check failed");

// next-cycle implication
`define IPDM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipdm check failed");

`endif

FILE: rtl/ipdm_pkg.sv
// shared types and constants of the pair mask block
// no dependencies
package ipdm_pkg;

   localparam int MAX_CELLS_DEFAULT = 12;
   localparam int MAX_SIGNS         = 16;
   localparam int SIGN_W            = 32;
   localparam int MASK_W            = 16;
   localparam int SIGN_COUNT_W      = 5;
   localparam int CSR_ADDR_W        = 3;
   localparam int CSR_DATA_W        = 32;

   localparam logic [SIGN_COUNT_W-1:0] SIGN_COUNT_RESET = SIGN_COUNT_W'(16);

   // register index, taken from paddr bit 2
   localparam logic CSR_REG_SIGN_COUNT = 1'b0;

   // truth labels
   localparam logic [1:0] TRUTH_FALSE = 2'd0;
   localparam logic [1:0] TRUTH_TRUE  = 2'd1;
   localparam logic [1:0] TRUTH_UNDET = 2'd2;

   // side hints
   localparam logic [1:0] HINT_FALSE = 2'd0;
   localparam logic [1:0] HINT_TRUE  = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEEK_OUTER,
      ST_SEEK_INNER,
      ST_COMPARE,
      ST_FINISH
   } state_type;

   // pair classes in emission order
   typedef enum logic [1:0] {
      PH_FU,
      PH_TU,
      PH_TF
   } phase_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;     // write the beat's signs into the store
      logic read;     // fetch both cells of a pair
      logic capture;  // park the new mask, push the parked one
      logic finish;   // push the last result of the run
      logic dropped;  // overflow flag of the current set
   } cmd_type;

endpackage

FILE: rtl/incompatible_pair_difference_masks.sv
// top level of the pair mask block: sequencer plus datapath
// depends on ipdm_pkg, ipdm_ctrl, ipdm_dp
//
//   channel  | ports            | beat
//   ---------+------------------+--------------------------------------
//   request  | req_*            | one cell: signs, truth, hint, final
//   response | rsp_*            | one pair mask with run flags
//   csr      | csr_* (apb-like) | sign_count at byte address 0
//
// a cell that is not final leaves the sequencer idle, so the next beat can be taken
// a final cell starts the pair walk: each outer cell costs a search step,
// each class pass one more, and each pair a store read and a compare;
// a full set of four cells per class gives up to 48 pairs
// requests are held off for the whole walk; a stalled response holds the walk
// synchronous reset clears the count, flags and handshake state, not the store
module incompatible_pair_difference_masks #(
   parameter int MAX_CELLS = ipdm_pkg::MAX_CELLS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ipdm_pkg::SIGN_W-1:0]          req_signs,
   input  logic [1:0]                           req_truth,
   input  logic [1:0]                           req_side_hint,
   input  logic                                 req_final_cell,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ipdm_pkg::MASK_W-1:0]          rsp_diff_mask,
   output logic                                 rsp_end_of_run,
   output logic                                 rsp_no_pairs,
   output logic                                 rsp_dropped,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ipdm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ipdm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ipdm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import ipdm_pkg::*;

   localparam int IDX_W = $clog2(MAX_CELLS);

   cmd_type           cmd;
   logic              out_free;
   logic [IDX_W-1:0]  wr_addr;
   logic [IDX_W-1:0]  rd_a;
   logic [IDX_W-1:0]  rd_b;

   // sequencer
   ipdm_ctrl #(
      .MAX_CELLS (MAX_CELLS),
      .IDX_W     (IDX_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_truth      (req_truth),
      .req_side_hint  (req_side_hint),
      .req_final_cell (req_final_cell),
      .out_free       (out_free),
      .cmd            (cmd),
      .wr_addr        (wr_addr),
      .rd_a           (rd_a),
      .rd_b           (rd_b)
   );

   // datapath
   ipdm_dp #(
      .MAX_CELLS (MAX_CELLS),
      .IDX_W     (IDX_W)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .wr_addr        (wr_addr),
      .rd_a           (rd_a),
      .rd_b           (rd_b),
      .wr_signs       (req_signs),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_diff_mask  (rsp_diff_mask),
      .rsp_end_of_run (rsp_end_of_run),
      .rsp_no_pairs   (rsp_no_pairs),
      .rsp_dropped    (rsp_dropped),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

endmodule

FILE: rtl/ipdm_ctrl.sv
// sequencer: cell count, class flags and the pair walk
// depends on ipdm_pkg
module ipdm_ctrl #(
   parameter int MAX_CELLS = ipdm_pkg::MAX_CELLS_DEFAULT,
   parameter int IDX_W     = $clog2(MAX_CELLS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_truth,
   input  logic [1:0]           req_side_hint,
   input  logic                 req_final_cell,
   input  logic                 out_free,
   output ipdm_pkg::cmd_type    cmd,
   output logic [IDX_W-1:0]     wr_addr,
   output logic [IDX_W-1:0]     rd_a,
   output logic [IDX_W-1:0]     rd_b
);
   import ipdm_pkg::*;

   localparam int CNT_W = $clog2(MAX_CELLS + 1);

   state_type              state_ff, state_in;
   phase_type              phase_ff, phase_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   overflow_ff, overflow_in;
   logic [IDX_W-1:0]       outer_ff, outer_in;
   logic [CNT_W-1:0]       ostart_ff, ostart_in;
   logic [CNT_W-1:0]       istart_ff, istart_in;
   logic [MAX_CELLS-1:0]   is_false_ff, is_false_in;
   logic [MAX_CELLS-1:0]   is_true_ff, is_true_in;
   logic [MAX_CELLS-1:0]   und_nf_ff, und_nf_in;
   logic [MAX_CELLS-1:0]   und_nt_ff, und_nt_in;

   logic                   accept;
   logic                   has_room;
   logic [MAX_CELLS-1:0]   outer_vec;
   logic [MAX_CELLS-1:0]   inner_vec;
   logic [CNT_W:0]         outer_hit;
   logic [CNT_W:0]         inner_hit;
   logic [CNT_W-1:0]       outer_next;

   // lowest set flag at or above start, with a found bit on top
   function automatic logic [CNT_W:0] first_from(input logic [MAX_CELLS-1:0] vec,
                                                 input logic [CNT_W-1:0] start);
      logic [CNT_W:0] res;
      res = '0;
      for (int k = MAX_CELLS - 1; k >= 0; k--) begin
         if (vec[k] && (CNT_W'(k) >= start)) begin
            res = {1'b1, CNT_W'(k)};
         end
      end
      return res;
   endfunction

   assign accept     = req_valid && req_ready;
   assign has_room   = count_ff < CNT_W'(MAX_CELLS);
   assign outer_next = CNT_W'(outer_ff) + CNT_W'(1);

   // class vectors for the current phase
   always_comb begin
      outer_vec = is_true_ff;
      inner_vec = is_false_ff;
      case (phase_ff)
         PH_FU: begin
            outer_vec = is_false_ff;
            inner_vec = und_nf_ff;
         end
         PH_TU: begin
            inner_vec = und_nt_ff;
         end
         default: begin
            inner_vec = is_false_ff;
         end
      endcase
   end

   assign outer_hit = first_from(outer_vec, ostart_ff);
   assign inner_hit = first_from(inner_vec, istart_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_final_cell) state_in = ST_SEEK_OUTER;
         end
         ST_SEEK_OUTER: begin
            if (outer_hit[CNT_W]) state_in = ST_SEEK_INNER;
            else if (phase_ff != PH_FU) state_in = ST_FINISH;
         end
         ST_SEEK_INNER: begin
            if (inner_hit[CNT_W]) state_in = ST_COMPARE;
            else if (phase_ff != PH_TU) state_in = ST_SEEK_OUTER;
         end
         ST_COMPARE: begin
            if (out_free) state_in = ST_SEEK_INNER;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = state_ff == ST_IDLE;
      cmd.load    = accept && has_room;
      cmd.read    = (state_ff == ST_SEEK_INNER) && inner_hit[CNT_W];
      cmd.capture = (state_ff == ST_COMPARE) && out_free;
      cmd.finish  = (state_ff == ST_FINISH) && out_free;
      cmd.dropped = overflow_ff;
      wr_addr     = count_ff[IDX_W-1:0];
      rd_a        = outer_ff;
      rd_b        = inner_hit[IDX_W-1:0];
   end

   // walk indices, count and class flags
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      outer_in    = outer_ff;
      ostart_in   = ostart_ff;
      istart_in   = istart_ff;
      is_false_in = is_false_ff;
      is_true_in  = is_true_ff;
      und_nf_in   = und_nf_ff;
      und_nt_in   = und_nt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (has_room) begin
                  is_false_in[wr_addr] = req_truth == TRUTH_FALSE;
                  is_true_in[wr_addr]  = req_truth == TRUTH_TRUE;
                  und_nf_in[wr_addr]   = (req_truth == TRUTH_UNDET) &&
                                         (req_side_hint != HINT_FALSE);
                  und_nt_in[wr_addr]   = (req_truth == TRUTH_UNDET) &&
                                         (req_side_hint != HINT_TRUE);
                  count_in             = count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               phase_in  = PH_FU;
               ostart_in = '0;
            end
         end
         ST_SEEK_OUTER: begin
            if (outer_hit[CNT_W]) begin
               outer_in  = outer_hit[IDX_W-1:0];
               istart_in = '0;
            end else if (phase_ff == PH_FU) begin
               phase_in  = PH_TU;
               ostart_in = '0;
            end
         end
         ST_SEEK_INNER: begin
            if (inner_hit[CNT_W]) begin
               istart_in = inner_hit[CNT_W-1:0] + CNT_W'(1);
            end else begin
               case (phase_ff)
                  PH_TU: begin
                     phase_in  = PH_TF;
                     istart_in = '0;
                  end
                  PH_TF: begin
                     phase_in  = PH_TU;
                     ostart_in = outer_next;
                  end
                  default: begin
                     ostart_in = outer_next;
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               count_in    = '0;
               overflow_in = 1'b0;
               is_false_in = '0;
               is_true_in  = '0;
               und_nf_in   = '0;
               und_nt_in   = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         phase_ff    <= PH_FU;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         is_false_ff <= '0;
         is_true_ff  <= '0;
         und_nf_ff   <= '0;
         und_nt_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         is_false_ff <= is_false_in;
         is_true_ff  <= is_true_in;
         und_nf_ff   <= und_nf_in;
         und_nt_ff   <= und_nt_in;
      end
   end

   // walk positions
   always_ff @(posedge clock) begin
      outer_ff  <= outer_in;
      ostart_ff <= ostart_in;
      istart_ff <= istart_in;
   end

endmodule

FILE: rtl/ipdm_dp.sv
// datapath: sign store, pair compare, parked mask, result register, csr
// depends on ipdm_pkg
module ipdm_dp #(
   parameter int MAX_CELLS = ipdm_pkg::MAX_CELLS_DEFAULT,
   parameter int IDX_W     = $clog2(MAX_CELLS)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ipdm_pkg::cmd_type                    cmd,
   input  logic [IDX_W-1:0]                     wr_addr,
   input  logic [IDX_W-1:0]                     rd_a,
   input  logic [IDX_W-1:0]                     rd_b,
   input  logic [ipdm_pkg::SIGN_W-1:0]          wr_signs,
   output logic                                 out_free,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ipdm_pkg::MASK_W-1:0]          rsp_diff_mask,
   output logic                                 rsp_end_of_run,
   output logic                                 rsp_no_pairs,
   output logic                                 rsp_dropped,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ipdm_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ipdm_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ipdm_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import ipdm_pkg::*;

   logic [SIGN_W-1:0]        sign_mem [MAX_CELLS];
   logic [SIGN_W-1:0]        rd_a_ff;
   logic [SIGN_W-1:0]        rd_b_ff;
   logic [SIGN_COUNT_W-1:0]  sign_count_ff, sign_count_in;
   logic [MASK_W-1:0]        mask;
   logic [MASK_W-1:0]        pend_mask_ff, pend_mask_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic                     out_valid_ff, out_valid_in;
   logic [MASK_W-1:0]        out_mask_ff, out_mask_in;
   logic                     out_eor_ff, out_eor_in;
   logic                     out_np_ff, out_np_in;
   logic                     out_drop_ff, out_drop_in;
   logic                     push;
   logic                     csr_wr;

   // sign store, one write and two registered reads
   always_ff @(posedge clock) begin
      if (cmd.load) sign_mem[wr_addr] <= wr_signs;
      if (cmd.read) begin
         rd_a_ff <= sign_mem[rd_a];
         rd_b_ff <= sign_mem[rd_b];
      end
   end

   // per-position compare over the active positions
   always_comb begin
      for (int j = 0; j < MASK_W; j++) begin
         mask[j] = (j < MAX_SIGNS) && (SIGN_COUNT_W'(j) < sign_count_ff) &&
                   (rd_a_ff[2*j +: 2] != rd_b_ff[2*j +: 2]);
      end
   end

   // parked mask and result register
   assign out_free = !out_valid_ff || rsp_ready;
   assign push     = (cmd.capture && pend_valid_ff) || cmd.finish;

   always_comb begin
      pend_mask_in  = pend_mask_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_mask_in   = out_mask_ff;
      out_eor_in    = out_eor_ff;
      out_np_in     = out_np_ff;
      out_drop_in   = out_drop_ff;
      if (push) begin
         out_valid_in = 1'b1;
         out_mask_in  = pend_valid_ff ? pend_mask_ff : '0;
         out_eor_in   = cmd.finish;
         out_np_in    = cmd.finish && !pend_valid_ff;
         out_drop_in  = cmd.dropped;
      end
      if (cmd.capture) begin
         pend_mask_in  = mask;
         pend_valid_in = 1'b1;
      end
      if (cmd.finish) pend_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_mask_ff <= pend_mask_in;
      out_mask_ff  <= out_mask_in;
      out_eor_ff   <= out_eor_in;
      out_np_ff    <= out_np_in;
      out_drop_ff  <= out_drop_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_diff_mask  = out_mask_ff;
   assign rsp_end_of_run = out_eor_ff;
   assign rsp_no_pairs   = out_np_ff;
   assign rsp_dropped    = out_drop_ff;

   // sign_count register
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == CSR_REG_SIGN_COUNT);

   always_comb begin
      sign_count_in = sign_count_ff;
      if (csr_wr) sign_count_in = csr_pwdata[SIGN_COUNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sign_count_ff <= SIGN_COUNT_RESET;
      end else begin
         sign_count_ff <= sign_count_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_REG_SIGN_COUNT) ?
                       CSR_DATA_W'(sign_count_ff) : '0;

endmodule

FILE: rtl/ipdm_checker.sv
// port-level checks for the pair mask block, bound to the top level
// depends on ipdm_pkg and incompatible_pair_difference_masks_assert.svh
`include "incompatible_pair_difference_masks_assert.svh"

module ipdm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_final_cell,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ipdm_pkg::MASK_W-1:0]  rsp_diff_mask,
   input logic                         rsp_end_of_run,
   input logic                         rsp_no_pairs
);
   import ipdm_pkg::*;

   // an empty run is a single closing beat with a clear mask
   `IPDM_ASSERT_IMP(a_empty_run, clock, reset, rsp_valid && rsp_no_pairs, rsp_end_of_run && (rsp_diff_mask == '0))

   // a final cell closes the request side while the walk runs
   `IPDM_ASSERT_NXT(a_final_blocks, clock, reset, req_valid && req_ready && req_final_cell, !req_ready)

   // a stalled response beat holds
   `IPDM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_diff_mask))

endmodule

bind incompatible_pair_difference_masks ipdm_checker u_ipdm_checker (.*);

FILE: test/incompatible_pair_difference_masks_test.sv
// self-checking testbench for the pair mask block: directed table, then random cell sets
// depends on ipdm_pkg and incompatible_pair_difference_masks
module incompatible_pair_difference_masks_test;
   import ipdm_pkg::*;

   localparam logic [1:0] TRUTH_IGNORED = 2'd3;
   localparam logic [1:0] HINT_NEITHER  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] SIGN_COUNT_ADDR = {CSR_REG_SIGN_COUNT, 2'b00};
   localparam int ITEM_TARGET   = 233;
   localparam int SETTLE_CYCLES = 150;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 2000;

   typedef struct packed {
      logic [MASK_W-1:0] diff_mask;
      logic              end_of_run;
      logic              no_pairs;
      logic              dropped;
   } pair_result_t;

   typedef struct packed {
      logic [SIGN_W-1:0] signs;
      logic [1:0]        truth;
      logic [1:0]        hint;
      logic              last;
      logic              typed;
      logic [MASK_W-1:0] mask;
      logic              no_pairs;
      logic              dropped;
   } opening_row_t;

   // opening sets; typed rows carry the single result expected from them
   localparam opening_row_t OPENING_ROWS [18] = '{
      // lone cell straight after reset: no pair
      '{32'h0000_0000, TRUTH_FALSE,   HINT_FALSE,   1'b1, 1'b1, 16'h0000, 1'b1, 1'b0},
      // all-zero against all-negative: every position differs
      '{32'h0000_0000, TRUTH_FALSE,   HINT_FALSE,   1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, TRUTH_UNDET,   HINT_NEITHER, 1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b0},
      // all-positive true cell against all-negative false cell
      '{32'h5555_5555, TRUTH_TRUE,    HINT_NEITHER, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, TRUTH_FALSE,   HINT_NEITHER, 1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b0},
      // every label and hint, store filled, final cell dropped
      '{32'h0000_0000, TRUTH_FALSE,   HINT_FALSE,   1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{32'hAAAA_AAAA, TRUTH_UNDET,   HINT_FALSE,   1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{32'h5555_5555, TRUTH_TRUE,    HINT_TRUE,    1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{32'hFFFF_0000, TRUTH_UNDET,   HINT_TRUE,    1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{32'h1234_5678, TRUTH_IGNORED, HINT_NEITHER, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{32'h0F0F_0F0F, TRUTH_UNDET,   HINT_NEITHER, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{32'hC3C3_C3C3, TRUTH_UNDET,   2'd3,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{32'hDEAD_BEEF, TRUTH_FALSE,   2'd3,         1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{32'h0000_FFFF, TRUTH_TRUE,    HINT_FALSE,   1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{32'hFFFF_FFFF, TRUTH_IGNORED, HINT_TRUE,    1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{32'h8000_0001, TRUTH_FALSE,   HINT_TRUE,    1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{32'h7FFF_FFFE, TRUTH_TRUE,    HINT_NEITHER, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
      '{32'h1111_1111, TRUTH_FALSE,   HINT_FALSE,   1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready;
   logic [SIGN_W-1:0] req_signs;
   logic [1:0] req_truth, req_side_hint;
   logic req_final_cell;
   logic rsp_valid, rsp_ready;
   logic [MASK_W-1:0] rsp_diff_mask;
   logic rsp_end_of_run, rsp_no_pairs, rsp_dropped;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   // predictor state
   logic [SIGN_W-1:0]       cell_signs [MAX_CELLS_DEFAULT];
   logic [1:0]              cell_truth [MAX_CELLS_DEFAULT];
   logic [1:0]              cell_hint  [MAX_CELLS_DEFAULT];
   int                      stored_cells;
   logic                    overflow_flag;
   logic [SIGN_COUNT_W-1:0] compare_width;

   pair_result_t pending_masks [$];
   int  mismatch_count;
   int  items_sent;
   int  quiet_cycles;
   bit  stall_request;
   bit  stall_active;

   always #5 clock = ~clock;

   incompatible_pair_difference_masks DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_signs      (req_signs),
      .req_truth      (req_truth),
      .req_side_hint  (req_side_hint),
      .req_final_cell (req_final_cell),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_diff_mask  (rsp_diff_mask),
      .rsp_end_of_run (rsp_end_of_run),
      .rsp_no_pairs   (rsp_no_pairs),
      .rsp_dropped    (rsp_dropped),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   task automatic note_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // positions where two stored vectors disagree, up to the live sign count
   function automatic logic [MASK_W-1:0] mask_between(input int a, input int b);
      logic [MASK_W-1:0] mask;
      int positions;
      mask = '0;
      positions = (compare_width > MAX_SIGNS) ? MAX_SIGNS : int'(compare_width);
      for (int j = 0; j < positions && j < MASK_W; j++) begin
         if (cell_signs[a][2*j +: 2] != cell_signs[b][2*j +: 2]) mask[j] = 1'b1;
      end
      return mask;
   endfunction

   // store one cell and, on the final one, walk the incompatible pairs
   function automatic void predict_cell(input logic [SIGN_W-1:0] signs,
                                        input logic [1:0] truth, input logic [1:0] hint,
                                        input logic last, output pair_result_t walk [$]);
      walk = {};
      if (stored_cells < MAX_CELLS_DEFAULT) begin
         cell_signs[stored_cells] = signs;
         cell_truth[stored_cells] = truth;
         cell_hint[stored_cells]  = hint;
         stored_cells++;
      end else begin
         overflow_flag = 1'b1;
      end
      if (!last) return;
      // false against undetermined not hinted false
      for (int f = 0; f < stored_cells; f++) begin
         if (cell_truth[f] != TRUTH_FALSE) continue;
         for (int u = 0; u < stored_cells; u++) begin
            if (cell_truth[u] == TRUTH_UNDET && cell_hint[u] != HINT_FALSE)
               walk.push_back('{mask_between(f, u), 1'b0, 1'b0, overflow_flag});
         end
      end
      // each true cell against undetermined not hinted true, then against false
      for (int t = 0; t < stored_cells; t++) begin
         if (cell_truth[t] != TRUTH_TRUE) continue;
         for (int u = 0; u < stored_cells; u++) begin
            if (cell_truth[u] == TRUTH_UNDET && cell_hint[u] != HINT_TRUE)
               walk.push_back('{mask_between(t, u), 1'b0, 1'b0, overflow_flag});
         end
         for (int f = 0; f < stored_cells; f++) begin
            if (cell_truth[f] == TRUTH_FALSE)
               walk.push_back('{mask_between(t, f), 1'b0, 1'b0, overflow_flag});
         end
      end
      if (walk.size() == 0) walk.push_back('{'0, 1'b0, 1'b1, overflow_flag});
      walk[walk.size() - 1].end_of_run = 1'b1;
      stored_cells  = 0;
      overflow_flag = 1'b0;
   endfunction

   // mostly back to back, sometimes a few cycles, rarely a long pause
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // offer one cell beat, predict on acceptance, then idle for the given gap
   task automatic send_cell(input logic [SIGN_W-1:0] signs, input logic [1:0] truth,
                            input logic [1:0] hint, input logic last, input int gap,
                            input logic typed, input pair_result_t typed_result);
      pair_result_t walk [$];
      @(negedge clock);
      req_valid      <= 1'b1;
      req_signs      <= signs;
      req_truth      <= truth;
      req_side_hint  <= hint;
      req_final_cell <= last;
      do @(posedge clock); while (!req_ready);
      predict_cell(signs, truth, hint, last, walk);
      if (typed) pending_masks.push_back(typed_result);
      else foreach (walk[i]) pending_masks.push_back(walk[i]);
      items_sent++;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] data,
                             output logic [CSR_DATA_W-1:0] rdata);
      // setup cycle, then access cycle
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= SIGN_COUNT_ADDR;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // read sign_count back and compare with the predictor's copy
   task automatic check_sign_count();
      logic [CSR_DATA_W-1:0] readback;
      csr_access(1'b0, '0, readback);
      if (readback[SIGN_COUNT_W-1:0] !== compare_width)
         note_mismatch($sformatf("sign_count read %0d, want %0d",
                                 readback[SIGN_COUNT_W-1:0], compare_width));
   endtask

   task automatic set_sign_count(input logic [SIGN_COUNT_W-1:0] value);
      logic [CSR_DATA_W-1:0] unused;
      csr_access(1'b1, CSR_DATA_W'(value), unused);
      compare_width = value;
      check_sign_count();
   endtask

   // stop offering, let every expected beat arrive and the walk wind down
   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_masks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result checker and activity count for the watchdog
   always @(posedge clock) begin : result_check
      pair_result_t want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable && csr_pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (rsp_valid && rsp_ready) begin
            if (pending_masks.size() == 0) begin
               note_mismatch($sformatf("unexpected beat, mask %h", rsp_diff_mask));
            end else begin
               want = pending_masks.pop_front();
               if (rsp_diff_mask !== want.diff_mask)
                  note_mismatch($sformatf("diff_mask %h, want %h",
                                          rsp_diff_mask, want.diff_mask));
               if (rsp_end_of_run !== want.end_of_run)
                  note_mismatch($sformatf("end_of_run %b, want %b",
                                          rsp_end_of_run, want.end_of_run));
               if (rsp_no_pairs !== want.no_pairs)
                  note_mismatch($sformatf("no_pairs %b, want %b",
                                          rsp_no_pairs, want.no_pairs));
               if (rsp_dropped !== want.dropped)
                  note_mismatch($sformatf("dropped %b, want %b",
                                          rsp_dropped, want.dropped));
            end
         end
      end
   end

   // watchdog on cycles with no beat on any port
   initial begin
      while (quiet_cycles < IDLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : result_sink
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (stall_request) begin
            stall_request = 1'b0;
            stall_active  = 1'b1;
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            stall_active = 1'b0;
         end
         gap = idle_length();
         if (gap > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 15)) @(negedge clock);
      end
   end

   // stimulus
   initial begin : stimulus
      logic [SIGN_COUNT_W-1:0] width_steps [6];
      logic [SIGN_W-1:0] base, signs;
      logic [1:0] truth, single_class;
      pair_result_t typed_result;
      int phase, budget, cells, pick, mode;
      bit burst;

      width_steps = '{5'd0, 5'd31, 5'd1, 5'd17, 5'd15, 5'd16};
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_signs      = '0;
      req_truth      = '0;
      req_side_hint  = '0;
      req_final_cell = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      stall_request  = 1'b0;
      stall_active   = 1'b0;
      mismatch_count = 0;
      items_sent     = 0;
      quiet_cycles   = 0;
      stored_cells   = 0;
      overflow_flag  = 1'b0;
      compare_width  = SIGN_COUNT_RESET;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register comes up at its reset value
      check_sign_count();

      // directed table
      foreach (OPENING_ROWS[k]) begin
         typed_result = '{OPENING_ROWS[k].mask, 1'b1, OPENING_ROWS[k].no_pairs,
                          OPENING_ROWS[k].dropped};
         send_cell(OPENING_ROWS[k].signs, OPENING_ROWS[k].truth, OPENING_ROWS[k].hint,
                   OPENING_ROWS[k].last, idle_length(), OPENING_ROWS[k].typed,
                   typed_result);
      end

      // random sets, one sign count setting per phase
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_for_idle();
         if (phase < 6) set_sign_count(width_steps[phase]);
         else set_sign_count(SIGN_COUNT_W'($urandom_range(0, 31)));

         // full store, 48 pairs, result side held off while cells keep coming
         if (phase == 1) begin
            stall_request = 1'b1;
            while (!stall_active) @(posedge clock);
            for (int k = 0; k < MAX_CELLS_DEFAULT; k++) begin
               truth = (k % 3 == 0) ? TRUTH_FALSE : (k % 3 == 1) ? TRUTH_TRUE : TRUTH_UNDET;
               send_cell($urandom, truth, HINT_NEITHER, k == MAX_CELLS_DEFAULT - 1,
                         0, 1'b0, '0);
            end
         end

         budget = items_sent + 30;
         while (items_sent < budget && items_sent < ITEM_TARGET) begin
            // set size: mostly mid-sized, some tiny, a few past capacity
            pick  = $urandom_range(0, 99);
            cells = (pick < 8)  ? $urandom_range(13, 15) :
                    (pick < 20) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            // mixed labels, a single label (no pairs), or plain noise
            mode         = $urandom_range(0, 19);
            single_class = 2'($urandom_range(0, 3));
            burst        = ($urandom_range(0, 3) == 0);
            base         = $urandom;
            for (int k = 0; k < cells; k++) begin
               if (mode <= 13) begin
                  pick  = $urandom_range(0, 15);
                  truth = (pick < 5)  ? TRUTH_FALSE :
                          (pick < 10) ? TRUTH_TRUE  :
                          (pick < 15) ? TRUTH_UNDET : TRUTH_IGNORED;
               end else if (mode <= 16) begin
                  truth = single_class;
               end else begin
                  truth = 2'($urandom_range(0, 3));
               end
               // near copies of one vector give sparse masks
               signs = $urandom_range(0, 1) ? (base ^ ($urandom & $urandom & $urandom))
                                            : $urandom;
               send_cell(signs, truth, 2'($urandom_range(0, 3)), k == cells - 1,
                         burst ? 0 : idle_length(), 1'b0, '0);
            end
         end
         phase++;
      end

      wait_for_idle();
      if (mismatch_count == 0 && pending_masks.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
